@@ rtl/core/metronome_click_tone_generator_defines.svh @@
// Assertion macros shared by the metronome click tone generator RTL.
// Depends on nothing; the files that carry assertions include it by name.
`ifndef METRONOME_CLICK_TONE_GENERATOR_DEFINES_SVH
`define METRONOME_CLICK_TONE_GENERATOR_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, checked on every rising clock edge out of reset.
`define MCT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// Next-cycle implication.
`define MCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define MCT_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define MCT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/core/mct_pkg.sv @@
// Shared widths, reset values, register indexes and types of the click tone generator.
// Depends on nothing; every other RTL file but the assertion header refers to it by scoped names.
package mct_pkg;

    localparam int LEN_W    = 20;
    localparam int AMP_W    = 15;
    localparam int PHASE_W  = 32;
    localparam int COUNT_W  = 7;
    localparam int SAMPLE_W = 16;
    localparam int DATA_W   = 32;

    localparam int NUM_REGS  = 6;
    localparam int REG_IDX_W = $clog2(NUM_REGS);
    localparam int ADDR_W    = REG_IDX_W + 2;

    localparam logic [REG_IDX_W-1:0] REG_PERIOD_LEN = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_TONE_LEN   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ATTACK_LEN = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DECAY_LEN  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PEAK_AMP   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_PHASE_STEP = 3'd5;

    localparam logic [LEN_W-1:0]   RST_PERIOD_LEN = 20'd24000;
    localparam logic [LEN_W-1:0]   RST_TONE_LEN   = 20'd4800;
    localparam logic [LEN_W-1:0]   RST_ATTACK_LEN = 20'd48;
    localparam logic [LEN_W-1:0]   RST_DECAY_LEN  = 20'd480;
    localparam logic [AMP_W-1:0]   RST_PEAK_AMP   = 15'd16384;
    localparam logic [PHASE_W-1:0] RST_PHASE_STEP = 32'd78741067;

    localparam int MAX_FRAMES_DEF = 64;
    localparam int SINE_DEPTH_DEF = 1024;
    localparam int QUEUE_DEPTH    = 2;

    typedef struct packed {
        logic [LEN_W-1:0]   period_len;
        logic [LEN_W-1:0]   tone_len;
        logic [LEN_W-1:0]   attack_len;
        logic [LEN_W-1:0]   decay_len;
        logic [AMP_W-1:0]   peak_amp;
        logic [PHASE_W-1:0] phase_step;
    } t_cfg;

    // One classified request: how many samples to produce and whether the
    // configuration was inconsistent when it was taken.
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               err;
    } t_req;

endpackage

@@ rtl/core/mct_in_if.sv @@
// Request channel of the click tone generator: valid, ready and the frame count.
// Depends on mct_pkg for the field width.
interface mct_in_if;
    logic                         valid;
    logic                         ready;
    logic [mct_pkg::COUNT_W-1:0]  frame_count;

    modport source (output valid, output frame_count, input ready);
    modport sink   (input valid, input frame_count, output ready);
endinterface

@@ rtl/core/mct_out_if.sv @@
// Sample channel of the click tone generator: valid, ready, one sample word and the last-frame and config-error flags.
// Depends on mct_pkg for the field widths.
interface mct_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [mct_pkg::SAMPLE_W-1:0] sample;
    logic                                last_frame;
    logic                                config_error;

    modport source (output valid, output sample, output last_frame, output config_error,
                    input ready);
    modport sink   (input valid, input sample, input last_frame, input config_error,
                    output ready);
endinterface

@@ rtl/core/mct_front.sv @@
// Front end: takes request words, clamps the frame count, drops empty requests
// and tags each with the configuration check. Depends on mct_pkg and mct_in_if.
module mct_front #(
    parameter int MAX_FRAMES = mct_pkg::MAX_FRAMES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mct_in_if.sink        i_req,
    input  mct_pkg::t_cfg i_cfg,
    input  logic          i_q_full,
    output logic          o_push,
    output mct_pkg::t_req o_req
);

    logic                         r_valid;
    mct_pkg::t_req                r_req;
    logic                         accept;
    logic [mct_pkg::COUNT_W-1:0]  count_sat;
    logic [mct_pkg::LEN_W:0]      ramp_sum;
    logic                         cfg_bad;

    assign i_req.ready = !r_valid || !i_q_full;
    assign accept      = i_req.valid && i_req.ready;
    assign o_push      = r_valid && !i_q_full;
    assign o_req       = r_req;

    assign count_sat = (i_req.frame_count > mct_pkg::COUNT_W'(MAX_FRAMES))
                     ? mct_pkg::COUNT_W'(MAX_FRAMES) : i_req.frame_count;

    // The two ramps must fit inside the tone, and the tone inside the period.
    assign ramp_sum = {1'b0, i_cfg.attack_len} + {1'b0, i_cfg.decay_len};
    assign cfg_bad  = (i_cfg.tone_len >= i_cfg.period_len)
                   || (ramp_sum > {1'b0, i_cfg.tone_len});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= (count_sat != '0);
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req.count <= count_sat;
            r_req.err   <= cfg_bad;
        end
    end

endmodule

@@ rtl/core/mct_queue.sv @@
// Short request queue between the front end and the sample engine.
// Depends on mct_pkg for the request type and depth; includes the assertion macros.
`include "metronome_click_tone_generator_defines.svh"

module mct_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mct_pkg::t_req i_req,
    output logic          o_full,
    output logic          o_valid,
    output mct_pkg::t_req o_req,
    input  logic          i_pop
);

    localparam int DEPTH = mct_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mct_pkg::t_req      r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [CNT_W-1:0]   r_cnt;
    logic [PTR_W-1:0]   n_wr;
    logic [PTR_W-1:0]   n_rd;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_req   = r_mem[r_rd];

    assign n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_req;
        end
    end

    `MCT_ASSERT_IMPLY(a_no_overflow, i_clk, i_rst_n, i_push, r_cnt != CNT_W'(DEPTH))

endmodule

@@ rtl/core/mct_div.sv @@
// Envelope ramp divider: amp * mul / den, one quotient bit per cycle after a registered
// multiply step. Depends on mct_pkg for the operand widths.
module mct_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [mct_pkg::AMP_W-1:0]  i_amp,
    input  logic [mct_pkg::LEN_W-1:0]  i_mul,
    input  logic [mct_pkg::LEN_W-1:0]  i_den,
    output logic                       o_done,
    output logic [mct_pkg::AMP_W-1:0]  o_quot
);

    localparam int AW    = mct_pkg::AMP_W;
    localparam int LW    = mct_pkg::LEN_W;
    localparam int NUM_W = AW + LW;
    localparam int CNT_W = $clog2(AW);

    logic             r_load;
    logic             r_run;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [AW-1:0]    r_amp;
    logic [LW-1:0]    r_mul;
    logic [LW-1:0]    r_den;
    logic [LW-1:0]    r_rem;
    logic [AW-1:0]    r_low;
    logic [AW-1:0]    r_quot;

    logic [NUM_W-1:0] prod;
    logic [LW:0]      trial;
    logic [LW:0]      diff;
    logic             ge;

    // The quotient is known to fit in AW bits, so the upper part of the
    // product is already below the divisor and seeds the remainder.
    assign prod  = NUM_W'(r_amp) * NUM_W'(r_mul);
    assign trial = {r_rem, r_low[AW-1]};
    assign ge    = (trial >= {1'b0, r_den});
    assign diff  = trial - {1'b0, r_den};

    assign o_done = r_done;
    assign o_quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load <= 1'b0;
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_load <= 1'b1;
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else if (r_load) begin
            r_load <= 1'b0;
            r_run  <= 1'b1;
        end else if (r_run && r_cnt == '0) begin
            r_run  <= 1'b0;
            r_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_amp <= i_amp;
            r_mul <= i_mul;
            r_den <= i_den;
        end
        if (r_load) begin
            r_rem  <= prod[NUM_W-1:AW];
            r_low  <= prod[AW-1:0];
            r_cnt  <= CNT_W'(AW - 1);
            r_quot <= '0;
        end else if (r_run) begin
            r_rem  <= ge ? diff[LW-1:0] : trial[LW-1:0];
            r_low  <= {r_low[AW-2:0], 1'b0};
            r_quot <= {r_quot[AW-2:0], ge};
            r_cnt  <= r_cnt - 1'b1;
        end
    end

endmodule

@@ rtl/core/mct_back.sv @@
// Sample engine: position and phase state, polynomial sine on a shared multiplier,
// envelope, and the output register. Depends on mct_pkg, mct_out_if and mct_div.
`include "metronome_click_tone_generator_defines.svh"

module mct_back #(
    parameter int SINE_TABLE_DEPTH = mct_pkg::SINE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  mct_pkg::t_cfg i_cfg,
    input  logic          i_q_valid,
    input  mct_pkg::t_req i_q_req,
    output logic          o_q_pop,
    mct_out_if.source     o_smp
);

    localparam int LW      = mct_pkg::LEN_W;
    localparam int AW      = mct_pkg::AMP_W;
    localparam int PW      = mct_pkg::PHASE_W;
    localparam int CW      = mct_pkg::COUNT_W;
    localparam int SW      = mct_pkg::SAMPLE_W;
    localparam int K_W     = $clog2(SINE_TABLE_DEPTH);
    localparam int QTR_W   = K_W - 2;
    localparam int X_SHIFT = 16 - QTR_W;
    localparam int MUL_W   = 17;
    localparam int PROD_W  = 2 * MUL_W;

    localparam logic [QTR_W:0]   QUARTER = (QTR_W + 1)'(1) << QTR_W;
    localparam logic [16:0]      COEF_A  = 17'd102944;
    localparam logic [15:0]      COEF_B  = 16'd42047;
    localparam logic [12:0]      COEF_C  = 13'd4640;
    localparam logic [AW-1:0]    MAG_MAX = {AW{1'b1}};

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_START = 4'd1;
    localparam logic [3:0] ST_SQ    = 4'd2;
    localparam logic [3:0] ST_CX    = 4'd3;
    localparam logic [3:0] ST_BX    = 4'd4;
    localparam logic [3:0] ST_AX    = 4'd5;
    localparam logic [3:0] ST_MAG   = 4'd6;
    localparam logic [3:0] ST_ENV   = 4'd7;
    localparam logic [3:0] ST_OUT   = 4'd8;

    logic [3:0]              r_state,   n_state;
    logic [CW-1:0]           r_left,    n_left;
    logic                    r_cur_err, n_cur_err;
    logic [LW-1:0]           r_pos,     n_pos;
    logic [PW-1:0]           r_phase,   n_phase;
    logic [MUL_W-1:0]        r_x,       n_x;
    logic [MUL_W-1:0]        r_x2,      n_x2;
    logic                    r_neg,     n_neg;
    logic                    r_use_div, n_use_div;
    logic [PROD_W-1:0]       r_prod,    n_prod;
    logic [AW-1:0]           r_mag,     n_mag;
    logic                    r_o_valid, n_o_valid;
    logic signed [SW-1:0]    r_o_sample, n_o_sample;
    logic                    r_o_last,  n_o_last;
    logic                    r_o_err,   n_o_err;

    logic                    wrap;
    logic [LW-1:0]           p;
    logic [PW-1:0]           ph;
    logic [LW:0]             p_inc;
    logic [K_W-1:0]          k;
    logic [QTR_W:0]          q;
    logic [MUL_W-1:0]        x_val;
    logic                    audible;
    logic                    in_attack;
    logic                    in_decay;
    logic [MUL_W-1:0]        mul_a;
    logic [MUL_W-1:0]        mul_b;
    logic [PROD_W-1:0]       prod;
    logic [16:0]             mag_raw;
    logic [AW-1:0]           env;
    logic [AW-1:0]           v;
    logic [SW-1:0]           v_ext;
    logic                    slot_free;
    logic                    div_start;
    logic [LW-1:0]           div_mul;
    logic [LW-1:0]           div_den;
    logic                    div_done;
    logic [AW-1:0]           div_quot;

    mct_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_amp   (i_cfg.peak_amp),
        .i_mul   (div_mul),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // A register write may leave the position past the period; it then
    // restarts the beat before the sample is formed.
    assign wrap  = (r_pos >= i_cfg.period_len);
    assign p     = wrap ? '0 : r_pos;
    assign ph    = wrap ? '0 : r_phase;
    assign p_inc = {1'b0, p} + 1'b1;

    // Quarter-wave folding of the quantized phase into a Q16 offset.
    assign k     = ph[PW-1 -: K_W];
    assign q     = k[QTR_W] ? (QUARTER - {1'b0, k[QTR_W-1:0]}) : {1'b0, k[QTR_W-1:0]};
    assign x_val = {q, {X_SHIFT{1'b0}}};

    assign audible   = (p < i_cfg.tone_len);
    assign in_attack = (p < i_cfg.attack_len);
    assign in_decay  = (i_cfg.decay_len != '0)
                    && (p >= (i_cfg.tone_len - i_cfg.decay_len));

    assign prod    = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign mag_raw = r_prod[33:17];
    assign env     = r_use_div ? div_quot : i_cfg.peak_amp;
    assign v       = r_prod[29:15];
    assign v_ext   = {1'b0, v};

    assign slot_free = !r_o_valid || o_smp.ready;

    assign o_smp.valid        = r_o_valid;
    assign o_smp.sample       = r_o_sample;
    assign o_smp.last_frame   = r_o_last;
    assign o_smp.config_error = r_o_err;

    always_comb begin
        n_state    = r_state;
        n_left     = r_left;
        n_cur_err  = r_cur_err;
        n_pos      = r_pos;
        n_phase    = r_phase;
        n_x        = r_x;
        n_x2       = r_x2;
        n_neg      = r_neg;
        n_use_div  = r_use_div;
        n_prod     = r_prod;
        n_mag      = r_mag;
        n_o_valid  = r_o_valid && !o_smp.ready;
        n_o_sample = r_o_sample;
        n_o_last   = r_o_last;
        n_o_err    = r_o_err;
        o_q_pop    = 1'b0;
        div_start  = 1'b0;
        div_mul    = p;
        div_den    = i_cfg.attack_len;
        mul_a      = '0;
        mul_b      = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop   = 1'b1;
                    n_left    = i_q_req.count;
                    n_cur_err = i_q_req.err;
                    n_state   = ST_START;
                end
            end
            ST_START: begin
                n_prod = '0;
                n_neg  = 1'b0;
                if (r_cur_err) begin
                    n_state = ST_OUT;
                end else begin
                    if (p_inc >= {1'b0, i_cfg.period_len}) begin
                        n_pos   = '0;
                        n_phase = '0;
                    end else begin
                        n_pos   = p_inc[LW-1:0];
                        n_phase = ph + i_cfg.phase_step;
                    end
                    if (audible) begin
                        n_x       = x_val;
                        n_neg     = k[K_W-1];
                        n_use_div = in_attack || in_decay;
                        if (in_attack) begin
                            div_start = 1'b1;
                        end else if (in_decay) begin
                            div_start = 1'b1;
                            div_mul   = i_cfg.tone_len - p;
                            div_den   = i_cfg.decay_len;
                        end
                        n_state = ST_SQ;
                    end else begin
                        n_state = ST_OUT;
                    end
                end
            end
            ST_SQ: begin
                mul_a   = r_x;
                mul_b   = r_x;
                n_prod  = prod;
                n_state = ST_CX;
            end
            ST_CX: begin
                mul_a   = MUL_W'(COEF_C);
                mul_b   = r_prod[32:16];
                n_x2    = r_prod[32:16];
                n_prod  = prod;
                n_state = ST_BX;
            end
            ST_BX: begin
                mul_a   = MUL_W'(COEF_B - {3'b0, r_prod[28:16]});
                mul_b   = r_x2;
                n_prod  = prod;
                n_state = ST_AX;
            end
            ST_AX: begin
                mul_a   = COEF_A - {1'b0, r_prod[31:16]};
                mul_b   = r_x;
                n_prod  = prod;
                n_state = ST_MAG;
            end
            ST_MAG: begin
                n_mag   = (mag_raw > {2'b0, MAG_MAX}) ? MAG_MAX : mag_raw[AW-1:0];
                n_state = ST_ENV;
            end
            ST_ENV: begin
                if (!r_use_div || div_done) begin
                    mul_a   = MUL_W'(env);
                    mul_b   = MUL_W'(r_mag);
                    n_prod  = prod;
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (slot_free) begin
                    n_o_valid  = 1'b1;
                    n_o_sample = r_neg ? (SW'(0) - v_ext) : v_ext;
                    n_o_last   = (r_left == CW'(1));
                    n_o_err    = r_cur_err;
                    n_left     = r_left - 1'b1;
                    n_state    = (r_left == CW'(1)) ? ST_IDLE : ST_START;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_left    <= '0;
            r_pos     <= '0;
            r_phase   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_left    <= n_left;
            r_pos     <= n_pos;
            r_phase   <= n_phase;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_err  <= n_cur_err;
        r_x        <= n_x;
        r_x2       <= n_x2;
        r_neg      <= n_neg;
        r_use_div  <= n_use_div;
        r_prod     <= n_prod;
        r_mag      <= n_mag;
        r_o_sample <= n_o_sample;
        r_o_last   <= n_o_last;
        r_o_err    <= n_o_err;
    end

    `MCT_ASSERT_IMPLY(a_left_nonzero, i_clk, i_rst_n, r_state != ST_IDLE, r_left != '0)
    `MCT_ASSERT_IMPLY(a_out_from_seq, i_clk, i_rst_n, $rose(r_o_valid), $past(r_state) == ST_OUT)
    `MCT_ASSERT_NEXT(a_env_waits, i_clk, i_rst_n, r_state == ST_ENV && r_use_div && !div_done, r_state == ST_ENV)

endmodule

@@ rtl/core/metronome_click_tone_generator.sv @@
// Channel   Dir  Handshake          Word contents
// i_req     in   valid / ready      frame_count (samples wanted, 0 is dropped, >MAX clamped)
// o_smp     out  valid / ready      sample, last_frame, config_error
// APB       in   psel/penable/...   six length, amplitude and phase-step registers
//
// The sample engine pops a request from the queue when idle; a silent or flagged sample
// goes straight to the output state, others pass the sine multiply steps, and a sample on
// an attack or decay ramp waits for the bit-serial envelope divider beside the multiplier.
// Reset is synchronous and active low; it restores the register defaults and clears
// the beat position, the sine phase and all handshake state.
// The front stage and queue keep taking request words while the output word stalls, until they are full.
//
// Top level of the click tone generator: register file, front end, queue, sample engine.
// Depends on mct_pkg, the two channel interfaces, mct_front, mct_queue and mct_back.
module metronome_click_tone_generator #(
    parameter int MAX_FRAMES       = mct_pkg::MAX_FRAMES_DEF,
    parameter int SINE_TABLE_DEPTH = mct_pkg::SINE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    mct_in_if.sink                      i_req,
    mct_out_if.source                   o_smp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mct_pkg::ADDR_W-1:0]  paddr,
    input  logic [mct_pkg::DATA_W-1:0]  pwdata,
    output logic [mct_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    localparam int LW = mct_pkg::LEN_W;
    localparam int AW = mct_pkg::AMP_W;
    localparam int PW = mct_pkg::PHASE_W;
    localparam int DW = mct_pkg::DATA_W;
    localparam int IW = mct_pkg::REG_IDX_W;

    mct_pkg::t_cfg  r_cfg;
    logic [IW-1:0]  reg_idx;
    logic           wr_en;

    logic           push;
    mct_pkg::t_req  push_req;
    logic           q_full;
    logic           q_valid;
    mct_pkg::t_req  q_req;
    logic           q_pop;

    // The register file answers every access at once; a write lands at the
    // edge that closes its access phase. Byte address bits below the word
    // offset are ignored.
    assign pready  = 1'b1;
    assign reg_idx = paddr[mct_pkg::ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.period_len <= mct_pkg::RST_PERIOD_LEN;
            r_cfg.tone_len   <= mct_pkg::RST_TONE_LEN;
            r_cfg.attack_len <= mct_pkg::RST_ATTACK_LEN;
            r_cfg.decay_len  <= mct_pkg::RST_DECAY_LEN;
            r_cfg.peak_amp   <= mct_pkg::RST_PEAK_AMP;
            r_cfg.phase_step <= mct_pkg::RST_PHASE_STEP;
        end else if (wr_en) begin
            case (reg_idx)
                mct_pkg::REG_PERIOD_LEN: r_cfg.period_len <= pwdata[LW-1:0];
                mct_pkg::REG_TONE_LEN:   r_cfg.tone_len   <= pwdata[LW-1:0];
                mct_pkg::REG_ATTACK_LEN: r_cfg.attack_len <= pwdata[LW-1:0];
                mct_pkg::REG_DECAY_LEN:  r_cfg.decay_len  <= pwdata[LW-1:0];
                mct_pkg::REG_PEAK_AMP:   r_cfg.peak_amp   <= pwdata[AW-1:0];
                mct_pkg::REG_PHASE_STEP: r_cfg.phase_step <= pwdata[PW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            mct_pkg::REG_PERIOD_LEN: prdata = DW'(r_cfg.period_len);
            mct_pkg::REG_TONE_LEN:   prdata = DW'(r_cfg.tone_len);
            mct_pkg::REG_ATTACK_LEN: prdata = DW'(r_cfg.attack_len);
            mct_pkg::REG_DECAY_LEN:  prdata = DW'(r_cfg.decay_len);
            mct_pkg::REG_PEAK_AMP:   prdata = DW'(r_cfg.peak_amp);
            mct_pkg::REG_PHASE_STEP: prdata = DW'(r_cfg.phase_step);
            default:                 prdata = '0;
        endcase
    end

    // Front end: one holding register that clamps the count and records
    // whether the lengths are consistent at the time the word was taken.
    mct_front #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cfg    (r_cfg),
        .i_q_full (q_full),
        .o_push   (push),
        .o_req    (push_req)
    );

    // Two-entry queue so the front end keeps taking words while the engine
    // works through a long request.
    mct_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (push_req),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_req   (q_req),
        .i_pop   (q_pop)
    );

    // Sample engine: walks the beat, forms sine times envelope one sample at a
    // time and holds each result in the output register until it is taken.
    mct_back #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_req   (q_req),
        .o_q_pop   (q_pop),
        .o_smp     (o_smp)
    );

endmodule
